/* design/qdiv_pkg.sv */
// Shared types and constants for the quantized int8 divide pipeline.
// Used by every module of the block but qdiv_div4; depends on nothing.
package qdiv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 40;

  localparam logic [31:0]       MULT_RESET = 32'h0001_0000;
  localparam logic signed [7:0] SAT_MAX    = 8'sd127;
  localparam logic signed [7:0] SAT_MIN    = -8'sd128;

  // Register map, word index taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DIVIDEND_ZERO = 2'd0,
    REG_DIVISOR_ZERO  = 2'd1,
    REG_RESULT_ZERO   = 2'd2,
    REG_RESCALE_MULT  = 2'd3
  } reg_idx_e;

  // Per-word flags that ride along the whole pipeline.
  typedef struct packed {
    logic neg;     // signs of the two operands differ
    logic dz;      // divisor minus its zero point is zero
    logic a_neg;   // dividend minus its zero point is negative
    logic last;
  } flags_t;

  typedef struct packed {
    logic [7:0] ma;
    logic [7:0] mb;
    flags_t     fl;
  } s1_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [7:0]        mb;
    flags_t            fl;
  } s2_t;

  typedef struct packed {
    logic [7:0]  p;
    logic [3:0]  qhi;
    logic [3:0]  xlo;
    logic [15:0] nlo;
    logic [7:0]  mb;
    logic        ovf;
    flags_t      fl;
  } s3_t;

  typedef struct packed {
    logic [7:0]  q;
    logic [7:0]  rem;
    logic [15:0] nlo;
    logic [7:0]  mb;
    logic        ovf;
    flags_t      fl;
  } s4_t;

endpackage

/* design/quantized_int8_divide.sv */
// Quantized int8 elementwise divide, five register stages deep.
// A word moves through the stage 1 to stage 5 registers in order; stage 5 is the output register.
// Throughput: one word per cycle unless the output stalls; each stage advances whenever
// its successor is empty or moving, so bubbles are squeezed out while the output is stalled.
// Reset (rst_ni, async, active low) empties the pipeline and restores the registers.
// Depends on qdiv_pkg, qdiv_operand, qdiv_div4 and qdiv_round.
module quantized_int8_divide (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input word
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  dividend_q_i,
  input  logic [7:0]  divisor_q_i,
  input  logic        last_in_i,
  // Output word
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  quotient_q_o,
  output logic        last_out_o
);
  import qdiv_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write them only while the pipeline is idle; the block
  // itself does not enforce this, and the stages read these values directly.
  // ---------------------------------------------------------------------------
  logic [7:0]  dividend_zero_q;
  logic [7:0]  divisor_zero_q;
  logic [7:0]  result_zero_q;
  logic [31:0] rescale_mult_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dividend_zero_q <= 8'd0;
      divisor_zero_q  <= 8'd0;
      result_zero_q   <= 8'd0;
      rescale_mult_q  <= MULT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIVIDEND_ZERO: dividend_zero_q <= pwdata[7:0];
        REG_DIVISOR_ZERO:  divisor_zero_q  <= pwdata[7:0];
        REG_RESULT_ZERO:   result_zero_q   <= pwdata[7:0];
        REG_RESCALE_MULT:  rescale_mult_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIVIDEND_ZERO: prdata = {24'd0, dividend_zero_q};
      REG_DIVISOR_ZERO:  prdata = {24'd0, divisor_zero_q};
      REG_RESULT_ZERO:   prdata = {24'd0, result_zero_q};
      REG_RESCALE_MULT:  prdata = rescale_mult_q;
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage flow control. Each stage loads when it is empty or when its
  // successor loads, so a stall at the output only stops the full stages.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: zero points removed, operands split into sign and magnitude.
  // ---------------------------------------------------------------------------
  s1_t s1_d, s1_q;

  qdiv_operand u_operand (
    .dividend_q_i    (dividend_q_i),
    .divisor_q_i     (divisor_q_i),
    .last_i          (last_in_i),
    .dividend_zero_i (dividend_zero_q),
    .divisor_zero_i  (divisor_zero_q),
    .s1_o            (s1_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator |a| * multiplier, an 8 x 32 product below 2^40.
  // ---------------------------------------------------------------------------
  s2_t s2_d, s2_q;

  always_comb begin
    s2_d.prod = {32'd0, s1_q.ma} * {8'd0, rescale_mult_q};
    s2_d.mb   = s1_q.mb;
    s2_d.fl   = s1_q.fl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_q <= s2_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the quotient floor(prod / (|b| << 16)) equals floor(X / |b|) with
  // X = prod >> 16. When X >= |b| << 8 the quotient is at least 256 and
  // saturates; otherwise it fits in 8 bits and the top nibble is found here.
  // ---------------------------------------------------------------------------
  s3_t        s3_d, s3_q;
  logic [23:0] x_hi;
  logic [7:0]  p3;
  logic [3:0]  q3;

  assign x_hi = s2_q.prod[PROD_W-1:FRAC_BITS];

  qdiv_div4 u_div_hi (
    .p_i    (x_hi[15:8]),
    .bits_i (x_hi[7:4]),
    .mb_i   (s2_q.mb),
    .p_o    (p3),
    .q_o    (q3)
  );

  always_comb begin
    s3_d.p   = p3;
    s3_d.qhi = q3;
    s3_d.xlo = x_hi[3:0];
    s3_d.nlo = s2_q.prod[FRAC_BITS-1:0];
    s3_d.mb  = s2_q.mb;
    s3_d.ovf = (x_hi >= {8'd0, s2_q.mb, 8'd0});
    s3_d.fl  = s2_q.fl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) s3_q <= s3_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: low nibble of the quotient and the final partial remainder.
  // ---------------------------------------------------------------------------
  s4_t        s4_d, s4_q;
  logic [7:0] p4;
  logic [3:0] q4;

  qdiv_div4 u_div_lo (
    .p_i    (s3_q.p),
    .bits_i (s3_q.xlo),
    .mb_i   (s3_q.mb),
    .p_o    (p4),
    .q_o    (q4)
  );

  always_comb begin
    s4_d.q   = {s3_q.qhi, q4};
    s4_d.rem = p4;
    s4_d.nlo = s3_q.nlo;
    s4_d.mb  = s3_q.mb;
    s4_d.ovf = s3_q.ovf;
    s4_d.fl  = s3_q.fl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) s4_q <= s4_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: the remainder, extended by the 16 discarded numerator bits,
  // decides rounding; then sign, result zero point and saturation. This is
  // the output register, which holds its word while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic [7:0] res_d, res_q;
  logic       last5_q;

  qdiv_round u_round (
    .s4_i          (s4_q),
    .result_zero_i (result_zero_q),
    .quotient_o    (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      res_q   <= res_d;
      last5_q <= s4_q.fl.last;
    end
  end

  assign out_valid_o  = v5_q;
  assign quotient_q_o = res_q;
  assign last_out_o   = last5_q;

  // ---------------------------------------------------------------------------
  // Checks on the pipeline's own logic.
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // With the output register empty, nothing can hold back the input.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // A zero divisor always leaves the block as a saturated value.
  a_zero_divisor_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && rdy5 && s4_q.fl.dz) |=>
      (quotient_q_o == SAT_MAX || quotient_q_o == SAT_MIN))
    else $error("zero divisor produced an unsaturated quotient");

  // A quotient of 256 or more saturates whatever the result zero point.
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && rdy5 && s4_q.ovf) |=>
      (quotient_q_o == SAT_MAX || quotient_q_o == SAT_MIN))
    else $error("oversized quotient did not saturate");
`endif

endmodule

/* design/qdiv_operand.sv */
// Operand stage: removes zero points and splits each operand into sign and magnitude.
// Depends on qdiv_pkg.
module qdiv_operand (
  input  logic [7:0]   dividend_q_i,
  input  logic [7:0]   divisor_q_i,
  input  logic         last_i,
  input  logic [7:0]   dividend_zero_i,
  input  logic [7:0]   divisor_zero_i,
  output qdiv_pkg::s1_t s1_o
);
  import qdiv_pkg::*;

  logic [8:0] a;
  logic [8:0] b;
  logic [8:0] abs_a;
  logic [8:0] abs_b;

  always_comb begin
    a = {dividend_q_i[7], dividend_q_i} - {dividend_zero_i[7], dividend_zero_i};
    b = {divisor_q_i[7], divisor_q_i} - {divisor_zero_i[7], divisor_zero_i};
    abs_a = a[8] ? (9'd0 - a) : a;
    abs_b = b[8] ? (9'd0 - b) : b;
    s1_o.ma       = abs_a[7:0];
    s1_o.mb       = abs_b[7:0];
    s1_o.fl.neg   = a[8] ^ b[8];
    s1_o.fl.dz    = (b == 9'd0);
    s1_o.fl.a_neg = a[8];
    s1_o.fl.last  = last_i;
  end

endmodule

/* design/qdiv_div4.sv */
// Four restoring-division steps on an 8-bit partial remainder.
// Depends on nothing; instantiated twice by the top level.
module qdiv_div4 (
  input  logic [7:0] p_i,
  input  logic [3:0] bits_i,
  input  logic [7:0] mb_i,
  output logic [7:0] p_o,
  output logic [3:0] q_o
);

  logic [7:0] p;
  logic [8:0] trial;

  always_comb begin
    p     = p_i;
    trial = 9'd0;
    q_o   = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      trial = {p, bits_i[i]};
      if (trial >= {1'b0, mb_i}) begin
        q_o[i] = 1'b1;
        p      = 8'(trial - {1'b0, mb_i});
      end else begin
        p      = trial[7:0];
      end
    end
    p_o = p;
  end

endmodule

/* design/qdiv_round.sv */
// Final stage: round half to even, apply sign, add the result zero point, saturate.
// Depends on qdiv_pkg.
module qdiv_round (
  input  qdiv_pkg::s4_t s4_i,
  input  logic [7:0]    result_zero_i,
  output logic [7:0]    quotient_o
);
  import qdiv_pkg::*;

  logic [8:0]         t;
  logic [8:0]         mb9;
  logic               low_nz;
  logic               gt;
  logic               tie;
  logic               inc;
  logic [8:0]         qr;
  logic signed [10:0] mag;
  logic signed [10:0] sq;
  logic signed [10:0] sum;

  always_comb begin
    t      = {s4_i.rem, s4_i.nlo[15]};
    mb9    = {1'b0, s4_i.mb};
    low_nz = |s4_i.nlo[14:0];
    gt     = (t > mb9) || ((t == mb9) && low_nz);
    tie    = (t == mb9) && !low_nz;
    inc    = gt || (tie && s4_i.q[0]);
    // Any quotient of 256 or more saturates regardless of the zero point.
    qr     = s4_i.ovf ? 9'd256 : ({1'b0, s4_i.q} + {8'd0, inc});
    mag    = signed'({2'b00, qr});
    sq     = s4_i.fl.neg ? -mag : mag;
    sum    = sq + signed'({{3{result_zero_i[7]}}, result_zero_i});

    if (s4_i.fl.dz) begin
      quotient_o = s4_i.fl.a_neg ? SAT_MIN : SAT_MAX;
    end else if (sum > 11'sd127) begin
      quotient_o = SAT_MAX;
    end else if (sum < -11'sd128) begin
      quotient_o = SAT_MIN;
    end else begin
      quotient_o = sum[7:0];
    end
  end

endmodule
